>>> rtl/adjacency_matrix_vertex_merge_top_macros.svh
// assertion macros used by the checker file
`ifndef ADJACENCY_MATRIX_VERTEX_MERGE_TOP_MACROS_SVH
`define ADJACENCY_MATRIX_VERTEX_MERGE_TOP_MACROS_SVH

// same-cycle implication, disabled during reset
`define AMVM_ASSERT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled during reset
`define AMVM_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/amvm_pkg.sv
// shared types and constants for the adjacency matrix vertex merge block
package amvm_pkg;

   // operation codes carried in the kind field
   localparam logic [2:0] KIND_ADD    = 3'd0;
   localparam logic [2:0] KIND_DELETE = 3'd1;
   localparam logic [2:0] KIND_MERGE  = 3'd2;
   localparam logic [2:0] KIND_READ   = 3'd3;
   localparam logic [2:0] KIND_CLEAR  = 3'd4;

   // reset value of the initial vertex count register
   localparam logic [4:0] INIT_COUNT_RESET = 5'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_MG_RD,
      ST_MG_RW,
      ST_FINISH
   } state_type;

   // row read address source
   typedef enum logic {
      RD_VERTEX,
      RD_SOURCE
   } rd_sel_type;

   typedef struct packed {
      logic       load_req;
      logic       rd_en;
      rd_sel_type rd_sel;
      logic       idx_clr;
      logic       idx_inc;
      logic       orig_ld;
      logic       merge_wr;
      logic       finish;
   } cmd_type;

   typedef struct packed {
      logic reject;
      logic merge_go;
      logic row_last;
      logic row_penult;
      logic out_free;
   } stat_type;

endpackage

>>> rtl/amvm_ctrl.sv
// sequencer for the adjacency matrix vertex merge block
module amvm_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  amvm_pkg::stat_type stat,
   output amvm_pkg::cmd_type  cmd
);

   amvm_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= amvm_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         amvm_pkg::ST_IDLE: begin
            if (req_valid) state_in = amvm_pkg::ST_CHECK;
         end
         amvm_pkg::ST_CHECK: begin
            state_in = stat.merge_go ? amvm_pkg::ST_MG_RD : amvm_pkg::ST_FINISH;
         end
         amvm_pkg::ST_MG_RD: begin
            state_in = stat.row_last ? amvm_pkg::ST_FINISH : amvm_pkg::ST_MG_RW;
         end
         amvm_pkg::ST_MG_RW: begin
            if (stat.row_penult) state_in = amvm_pkg::ST_FINISH;
         end
         amvm_pkg::ST_FINISH: begin
            if (stat.out_free) state_in = amvm_pkg::ST_IDLE;
         end
         default: begin
            state_in = amvm_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_ready = 1'b0;
      cmd       = '0;
      case (state_ff)
         amvm_pkg::ST_IDLE: begin
            req_ready    = 1'b1;
            cmd.load_req = req_valid;
         end
         amvm_pkg::ST_CHECK: begin
            cmd.rd_en   = 1'b1;
            cmd.rd_sel  = amvm_pkg::RD_VERTEX;
            cmd.idx_clr = 1'b1;
         end
         amvm_pkg::ST_MG_RD: begin
            cmd.orig_ld = 1'b1;
            cmd.rd_en   = 1'b1;
            cmd.rd_sel  = amvm_pkg::RD_SOURCE;
         end
         amvm_pkg::ST_MG_RW: begin
            cmd.merge_wr = 1'b1;
            cmd.idx_inc  = 1'b1;
            cmd.rd_en    = 1'b1;
            cmd.rd_sel   = amvm_pkg::RD_SOURCE;
         end
         amvm_pkg::ST_FINISH: begin
            cmd.finish = stat.out_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

>>> rtl/amvm_dp.sv
// datapath: row memory, vertex count, merge row logic and result register
module amvm_dp #(
   parameter int MAX_VERTICES = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic [2:0]         req_kind,
   input  logic [3:0]         req_first_vertex,
   input  logic [3:0]         req_second_vertex,
   input  logic               csr_valid,
   input  logic [4:0]         csr_initial_vertex_count,
   input  logic               rsp_ready,
   input  amvm_pkg::cmd_type  cmd,
   output amvm_pkg::stat_type stat,
   output logic               rsp_valid,
   output logic               rsp_status,
   output logic [15:0]        rsp_row_bits,
   output logic [4:0]         rsp_vertex_count
);

   localparam int AW = $clog2(MAX_VERTICES);
   localparam int CW = $clog2(MAX_VERTICES + 1);
   localparam int XW = (CW > 4) ? CW : 4;
   localparam int YW = (CW > 5) ? CW : 5;
   localparam int SW = CW + 1;

   logic [2:0]              kind_ff;
   logic [3:0]              va_ff, vb_ff;
   logic [CW-1:0]           count_ff, count_in;
   logic [4:0]              init_ff;
   logic [MAX_VERTICES-1:0] mem [MAX_VERTICES];
   logic [MAX_VERTICES-1:0] valid_ff;
   logic [MAX_VERTICES-1:0] rd_data_ff;
   logic                    rd_vld_ff;
   logic [MAX_VERTICES-1:0] orig_ff;
   logic [AW-1:0]           idx_ff, idx_in;
   logic                    rsp_valid_ff;
   logic                    rsp_status_ff;
   logic [15:0]             rsp_row_bits_ff;
   logic [4:0]              rsp_vertex_count_ff;

   logic [XW-1:0]           a_x, b_x, cnt_x, max_x, max_ab;
   logic [AW-1:0]           addr_a, addr_b, rd_addr, wr_addr;
   logic                    reject;
   logic [MAX_VERTICES-1:0] row_eff, bit_a, bit_b, low_a, r1, merged, wr_data;
   logic [SW-1:0]           src_cur, src_nxt;
   logic [CW-1:0]           top, sat;
   logic [YW-1:0]           init_y;
   logic                    wr_en, clr_all;

   // range checks against storage size and current count
   assign a_x    = XW'(va_ff);
   assign b_x    = XW'(vb_ff);
   assign cnt_x  = XW'(count_ff);
   assign max_x  = XW'(MAX_VERTICES);
   assign addr_a = a_x[AW-1:0];
   assign addr_b = b_x[AW-1:0];

   always_comb begin
      case (kind_ff)
         amvm_pkg::KIND_ADD:    reject = !((a_x < max_x) && (b_x < max_x));
         amvm_pkg::KIND_DELETE: reject = !((a_x < cnt_x) && (b_x < cnt_x));
         amvm_pkg::KIND_MERGE:  reject = !((a_x < cnt_x) && (b_x < cnt_x));
         amvm_pkg::KIND_READ:   reject = !(a_x < cnt_x);
         amvm_pkg::KIND_CLEAR:  reject = 1'b0;
         default:               reject = 1'b1;
      endcase
   end

   // rows never written since clear read as zero
   assign row_eff = rd_vld_ff ? rd_data_ff : '0;
   assign bit_a   = MAX_VERTICES'(1) << addr_a;
   assign bit_b   = MAX_VERTICES'(1) << addr_b;
   assign low_a   = bit_a - MAX_VERTICES'(1);

   // row counter and source row (skips the merged-away row)
   always_comb begin
      if (cmd.idx_clr) begin
         idx_in = '0;
      end else if (cmd.idx_inc) begin
         idx_in = idx_ff + AW'(1);
      end else begin
         idx_in = idx_ff;
      end
   end

   assign src_cur = SW'(idx_ff) + ((SW'(idx_ff) >= SW'(addr_a)) ? SW'(1) : SW'(0));
   assign src_nxt = SW'(idx_in) + ((SW'(idx_in) >= SW'(addr_a)) ? SW'(1) : SW'(0));
   assign rd_addr = (cmd.rd_sel == amvm_pkg::RD_SOURCE) ? src_nxt[AW-1:0] : addr_a;

   // redirect in-edges, fold out-edges into the receiver, then drop the column
   assign r1 = row_eff
             | (row_eff[addr_a] ? bit_b : '0)
             | ((src_cur == SW'(addr_b)) ? (orig_ff & ~bit_a) : '0);
   assign merged = (r1 & low_a) | ((r1 >> 1) & ~low_a);

   assign max_ab = (a_x > b_x) ? a_x : b_x;
   assign top    = CW'(max_ab) + CW'(1);
   assign init_y = YW'(init_ff);
   assign sat    = (init_y > YW'(MAX_VERTICES)) ? CW'(MAX_VERTICES) : CW'(init_y);

   always_comb begin
      wr_en    = 1'b0;
      wr_addr  = idx_ff;
      wr_data  = merged;
      clr_all  = 1'b0;
      count_in = count_ff;
      if (cmd.merge_wr) begin
         wr_en = 1'b1;
      end
      if (cmd.finish && !reject) begin
         case (kind_ff)
            amvm_pkg::KIND_ADD: begin
               wr_en    = 1'b1;
               wr_addr  = addr_a;
               wr_data  = row_eff | bit_b;
               count_in = (top > count_ff) ? top : count_ff;
            end
            amvm_pkg::KIND_DELETE: begin
               wr_en   = 1'b1;
               wr_addr = addr_a;
               wr_data = row_eff & ~bit_b;
            end
            amvm_pkg::KIND_MERGE: begin
               wr_en    = 1'b1;
               wr_data  = '0;
               count_in = count_ff - CW'(1);
            end
            amvm_pkg::KIND_CLEAR: begin
               clr_all  = 1'b1;
               count_in = sat;
            end
            default: begin
               wr_en = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      if (cmd.rd_en) begin
         rd_data_ff <= mem[rd_addr];
         rd_vld_ff  <= valid_ff[rd_addr];
      end
      if (cmd.orig_ld) orig_ff <= row_eff;
      if (cmd.load_req) begin
         kind_ff <= req_kind;
         va_ff   <= req_first_vertex;
         vb_ff   <= req_second_vertex;
      end
      idx_ff <= idx_in;
      if (cmd.finish) begin
         rsp_status_ff       <= reject;
         rsp_row_bits_ff     <= (kind_ff == amvm_pkg::KIND_READ && !reject) ?
                                16'(row_eff) : 16'd0;
         rsp_vertex_count_ff <= 5'(count_in);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         count_ff     <= '0;
         init_ff      <= amvm_pkg::INIT_COUNT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (clr_all) begin
            valid_ff <= '0;
         end else if (wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
         count_ff <= count_in;
         if (csr_valid) init_ff <= csr_initial_vertex_count;
         if (cmd.finish) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign stat.reject     = reject;
   assign stat.merge_go   = (kind_ff == amvm_pkg::KIND_MERGE) && !reject;
   assign stat.row_last   = (SW'(idx_ff) + SW'(1)) == SW'(count_ff);
   assign stat.row_penult = (SW'(idx_ff) + SW'(2)) == SW'(count_ff);
   assign stat.out_free   = !rsp_valid_ff || rsp_ready;

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_row_bits     = rsp_row_bits_ff;
   assign rsp_vertex_count = rsp_vertex_count_ff;

endmodule

>>> rtl/adjacency_matrix_vertex_merge_top.sv
// top level of the directed graph adjacency matrix with vertex merge
//
//   channel  direction  signals
//   req      in         req_valid req_ready req_kind req_first_vertex req_second_vertex
//   rsp      out        rsp_valid rsp_ready rsp_status rsp_row_bits rsp_vertex_count
//   csr      in         csr_valid csr_ready csr_initial_vertex_count
//
// one operation at a time; add, delete, read, clear and rejected beats go from accept
// through the check and finish states and load their result in finish; merge goes
// through check, merge read and merge rewrite states before finish, one row rewritten per cycle
// through the single read and single write port of the row memory
// reset clears per-row valid bits at once, no clearing pass; csr is always ready
// a result held in the output register stalls only the final cycle of the next beat
module adjacency_matrix_vertex_merge_top #(
   parameter int MAX_VERTICES = 16
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_kind,
   input  logic [3:0]  req_first_vertex,
   input  logic [3:0]  req_second_vertex,
   // response channel
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_status,
   output logic [15:0] rsp_row_bits,
   output logic [4:0]  rsp_vertex_count,
   // configuration write
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [4:0]  csr_initial_vertex_count
);

   amvm_pkg::cmd_type  cmd;
   amvm_pkg::stat_type stat;

   // register writes land in the next cycle, never back-pressured
   assign csr_ready = 1'b1;

   // sequencer: decode, merge row sweep, result hand-off
   amvm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // row memory, count, merge row logic and output register
   amvm_dp #(
      .MAX_VERTICES (MAX_VERTICES)
   ) u_dp (
      .clock                    (clock),
      .reset                    (reset),
      .req_kind                 (req_kind),
      .req_first_vertex         (req_first_vertex),
      .req_second_vertex        (req_second_vertex),
      .csr_valid                (csr_valid),
      .csr_initial_vertex_count (csr_initial_vertex_count),
      .rsp_ready                (rsp_ready),
      .cmd                      (cmd),
      .stat                     (stat),
      .rsp_valid                (rsp_valid),
      .rsp_status               (rsp_status),
      .rsp_row_bits             (rsp_row_bits),
      .rsp_vertex_count         (rsp_vertex_count)
   );

endmodule

>>> rtl/amvm_chk.sv
// port-level checker for the adjacency matrix vertex merge block, with bind
`include "adjacency_matrix_vertex_merge_top_macros.svh"

module amvm_chk #(
   parameter int MAX_VERTICES = 16
) (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic        rsp_status,
   input logic [15:0] rsp_row_bits,
   input logic [4:0]  rsp_vertex_count
);

   logic        req_beat;
   logic        rsp_stall;
   logic        rsp_reject;
   logic        cnt_over;
   logic [22:0] rsp_beat;

   assign req_beat   = req_valid && req_ready;
   assign rsp_stall  = rsp_valid && !rsp_ready;
   assign rsp_reject = rsp_valid && rsp_status;
   assign rsp_beat   = {rsp_valid, rsp_status, rsp_row_bits, rsp_vertex_count};
   // count only checked when it fits the field
   assign cnt_over   = (MAX_VERTICES < 32) && (int'(rsp_vertex_count) > MAX_VERTICES);

   // stalled result holds
   `AMVM_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_stall, $stable(rsp_beat), "stalled rsp beat changed")

   // one operation in flight: no back-to-back request beats
   `AMVM_ASSERT_NXT(a_one_busy, clock, reset, req_beat, !req_ready, "request taken while busy")

   // a rejected beat carries no row mask
   `AMVM_ASSERT(a_rej_row, clock, reset, rsp_reject, rsp_row_bits == 16'd0, "row bits on rejected beat")

   // count never exceeds storage when it fits the field
   `AMVM_ASSERT(a_cnt_max, clock, reset, rsp_valid, !cnt_over, "vertex count beyond storage")

endmodule

bind adjacency_matrix_vertex_merge_top amvm_chk #(.MAX_VERTICES(MAX_VERTICES)) u_chk (.*);
